// File: sv/tsd_pkg.sv
// shared types and constants of the task slot dispatcher
`default_nettype none
package tsd_pkg;

  localparam int TASK_SLOTS_DEF  = 8;
  localparam int MAX_CLIENTS_DEF = 16;

  localparam int CIDX_W = 8;
  localparam int MASK_W = 16;

  localparam logic [7:0]  CAP_RESET = 8'd4;
  localparam logic [31:0] MS_PER_S  = 32'd1000;
  // ceil(2^41 / 1000), exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP_MS  = 32'd2199023256;
  localparam int          RECIP_SH  = 41;

  typedef enum logic [1:0] {
    RC_OK     = 2'd0,
    RC_CHANGE = 2'd1,
    RC_WAIT   = 2'd2,
    RC_FULL   = 2'd3
  } reply_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] client_id;
    logic [3:0]  task_index;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  reply_code;
    logic [3:0]  granted_task;
    logic        close_matched;
    logic [22:0] run_seconds;
  } out_t;

  // search token travelling along the client cells
  typedef struct packed {
    logic              act;
    logic [15:0]       key;
    logic              hit;
    logic [CIDX_W-1:0] hit_idx;
    logic [MASK_W-1:0] done;
    logic              free_found;
    logic [CIDX_W-1:0] free_idx;
  } tok_t;

  // entry write broadcast to the cells
  typedef struct packed {
    logic              en;
    logic [CIDX_W-1:0] idx;
    logic [15:0]       key;
    logic [MASK_W-1:0] done;
  } cwr_t;

endpackage
`default_nettype wire

// File: sv/tsd_ram.sv
// generic single port ram with registered read
`default_nettype none
module tsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: sv/tsd_cell.sv
// one client table entry, passing the search token to its neighbour
`default_nettype none
module tsd_cell #(
  parameter int MY_IDX = 0,
  parameter int TASK_SLOTS = tsd_pkg::TASK_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tsd_pkg::tok_t tok_in,
  input  wire tsd_pkg::cwr_t wr,
  output tsd_pkg::tok_t      tok_out
);

  localparam logic [tsd_pkg::CIDX_W-1:0] ME = tsd_pkg::CIDX_W'(MY_IDX);

  logic                    valid_r;
  logic [15:0]             key_r;
  logic [TASK_SLOTS-1:0]   done_r;
  tsd_pkg::tok_t           tok_r, tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.act) begin
      if (!tok_in.hit && valid_r && key_r == tok_in.key) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = ME;
        tok_nxt.done    = tsd_pkg::MASK_W'(done_r);
      end
      if (!tok_in.free_found && !valid_r) begin
        tok_nxt.free_found = 1'b1;
        tok_nxt.free_idx   = ME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.act   <= 1'b0;
    end else begin
      tok_r.act <= tok_nxt.act;
      if (wr.en && wr.idx == ME) begin
        valid_r <= 1'b1;
      end
    end
    tok_r.key        <= tok_nxt.key;
    tok_r.hit        <= tok_nxt.hit;
    tok_r.hit_idx    <= tok_nxt.hit_idx;
    tok_r.done       <= tok_nxt.done;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.free_idx   <= tok_nxt.free_idx;
    if (wr.en && wr.idx == ME) begin
      key_r  <= wr.key;
      done_r <= wr.done[TASK_SLOTS-1:0];
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// File: sv/task_slot_dispatcher.sv
// top level of the task slot dispatcher: sequencer, live counts and client cell row
//
// Requests enter on in_valid/in_data and are taken while in_stall is low; one
// result per request leaves on out_valid/out_data, taken while out_stall is low.
// The concurrency cap is written through cfg_valid/cfg_data when cfg_ready is high.
// A request walks a search token through the row of MAX_CLIENTS client cells,
// one cell per cycle, then passes through further sequencer states: a granted
// query goes S_EVAL, S_OUT; a reassignment S_EVAL, S_ASGN, S_OUT; a new client
// S_EVAL, S_NEWC, S_ASGN, S_OUT; and a matched close S_EVAL, S_RD, S_MUL,
// S_CLOSE, S_ASGN, S_OUT (stamp read, reciprocal multiply for the seconds).
// One request is in flight at a time, so the next transfer is taken no earlier
// than the cycle after the result is loaded.
// After reset the client table is empty, all live counts are zero and the cap
// is 4; no clearing pass is needed. While out_stall holds a result, the result
// stays in the output register and the block can still take one new transfer,
// finishing it up to the output stage.
`default_nettype none
module task_slot_dispatcher #(
  parameter int TASK_SLOTS  = tsd_pkg::TASK_SLOTS_DEF,
  parameter int MAX_CLIENTS = tsd_pkg::MAX_CLIENTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tsd_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output tsd_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_data
);

  localparam int DEPTH = MAX_CLIENTS * TASK_SLOTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRCH  = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_RD    = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_CLOSE = 9'b000100000,
    S_NEWC  = 9'b001000000,
    S_ASGN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t                         state_r, state_nxt;
  tsd_pkg::in_t                   req_r;
  tsd_pkg::tok_t                  inj_r;
  tsd_pkg::tok_t                  tok [MAX_CLIENTS+1];
  tsd_pkg::cwr_t                  cwr;
  logic                           hit_r, hit_nxt;
  logic                           free_r;
  logic [tsd_pkg::CIDX_W-1:0]     cidx_r, cidx_nxt, fidx_r;
  logic [TASK_SLOTS-1:0]          done_r, done_nxt;
  logic [7:0]                     live_r [TASK_SLOTS];
  logic [7:0]                     live_nxt [TASK_SLOTS];
  logic [7:0]                     cap_r;
  logic [31:0]                    diff_r, diff_nxt;
  logic [63:0]                    prod_r;
  tsd_pkg::out_t                  res_r, res_nxt;
  logic                           out_valid_r;
  tsd_pkg::out_t                  out_r;
  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [31:0]                    ram_q;
  logic [TASK_SLOTS-1:0]          grant;
  logic                           any_grant;
  logic [TW-1:0]                  first_t;
  logic                           ti_ok;
  logic [TW-1:0]                  ti;
  logic                           in_xfer, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ti    = req_r.task_index[TW-1:0];
  assign ti_ok = 32'(req_r.task_index) < TASK_SLOTS;

  assign tok[0] = inj_r;

  for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
    tsd_cell #(.MY_IDX(i), .TASK_SLOTS(TASK_SLOTS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .wr      (cwr),
      .tok_out (tok[i+1])
    );
  end

  tsd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stamp (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req_r.now_ms),
    .rdata (ram_q)
  );

  // grantable tasks against the current done mask and the cap, and the lowest of them
  always_comb begin
    any_grant = 1'b0;
    first_t   = '0;
    for (int t = 0; t < TASK_SLOTS; t++) begin
      grant[t] = !done_r[t] && (live_r[t] < cap_r);
    end
    for (int t = TASK_SLOTS - 1; t >= 0; t--) begin
      if (grant[t]) begin
        any_grant = 1'b1;
        first_t   = TW'(t);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    cidx_nxt  = cidx_r;
    done_nxt  = done_r;
    diff_nxt  = diff_r;
    res_nxt   = res_r;
    live_nxt  = live_r;
    ram_we    = 1'b0;
    ram_addr  = AW'(32'(cidx_r) * 32'(TASK_SLOTS) + 32'(ti));
    cwr.en    = 1'b0;
    cwr.idx   = cidx_r;
    cwr.key   = req_r.client_id;
    cwr.done  = tsd_pkg::MASK_W'(done_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (tok[MAX_CLIENTS].act) begin
          hit_nxt   = tok[MAX_CLIENTS].hit;
          cidx_nxt  = tok[MAX_CLIENTS].hit_idx;
          done_nxt  = tok[MAX_CLIENTS].done[TASK_SLOTS-1:0];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!req_r.req_type && hit_r && ti_ok && grant[ti]) begin
          ram_we               = 1'b1;
          live_nxt[ti]         = live_r[ti] + 8'd1;
          res_nxt.reply_code   = tsd_pkg::RC_OK;
          res_nxt.granted_task = req_r.task_index;
          state_nxt            = S_OUT;
        end else if (req_r.req_type && hit_r && ti_ok) begin
          state_nxt = S_RD;
        end else if (hit_r) begin
          state_nxt = S_ASGN;
        end else if (free_r) begin
          state_nxt = S_NEWC;
        end else begin
          res_nxt.reply_code = tsd_pkg::RC_FULL;
          state_nxt          = S_OUT;
        end
      end
      S_RD: begin
        diff_nxt  = (req_r.now_ms > ram_q) ? req_r.now_ms - ram_q : 32'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        res_nxt.run_seconds   = prod_r[tsd_pkg::RECIP_SH +: 23];
        res_nxt.close_matched = 1'b1;
        done_nxt              = done_r | (TASK_SLOTS'(1) << ti);
        cwr.en                = 1'b1;
        cwr.done              = tsd_pkg::MASK_W'(done_nxt);
        if (live_r[ti] != 8'd0) begin
          live_nxt[ti] = live_r[ti] - 8'd1;
        end
        state_nxt = S_ASGN;
      end
      S_NEWC: begin
        cwr.en    = 1'b1;
        cwr.idx   = fidx_r;
        cwr.done  = '0;
        ram_we    = 1'b1;
        ram_addr  = AW'(32'(fidx_r) * 32'(TASK_SLOTS));
        hit_nxt   = 1'b1;
        cidx_nxt  = fidx_r;
        done_nxt  = '0;
        state_nxt = S_ASGN;
      end
      S_ASGN: begin
        if (any_grant) begin
          ram_we               = 1'b1;
          ram_addr             = AW'(32'(cidx_r) * 32'(TASK_SLOTS) + 32'(first_t));
          live_nxt[first_t]    = live_r[first_t] + 8'd1;
          res_nxt.reply_code   = tsd_pkg::RC_CHANGE;
          res_nxt.granted_task = 4'(first_t);
        end else begin
          res_nxt.reply_code = tsd_pkg::RC_WAIT;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inj_r.act   <= 1'b0;
      cap_r       <= tsd_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TASK_SLOTS; t++) begin
        live_r[t] <= 8'd0;
      end
    end else begin
      state_r   <= state_nxt;
      inj_r.act <= in_xfer;
      live_r    <= live_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    // search token payload
    inj_r.key        <= in_data.client_id;
    inj_r.hit        <= 1'b0;
    inj_r.hit_idx    <= '0;
    inj_r.done       <= '0;
    inj_r.free_found <= 1'b0;
    inj_r.free_idx   <= '0;
    if (in_xfer) begin
      req_r <= in_data;
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
    if (state_r == S_SRCH) begin
      free_r <= tok[MAX_CLIENTS].free_found;
      fidx_r <= tok[MAX_CLIENTS].free_idx;
    end
    hit_r  <= hit_nxt;
    cidx_r <= cidx_nxt;
    done_r <= done_nxt;
    diff_r <= diff_nxt;
    prod_r <= diff_r * tsd_pkg::RECIP_MS;
    if (state_r == S_OUT && out_free) begin
      out_r <= res_r;
    end
  end

endmodule
`default_nettype wire
